// ----- hw/rtl/pta_pkg.sv -----
package pta_pkg;

  localparam int TableEntries = 16;
  localparam int SlotW = 4;
  localparam int CountW = 5;
  localparam int MinPacketLen = 32;

  localparam logic [1:0] ACT_ANNOUNCE = 2'd0;
  localparam logic [1:0] ACT_SWEEP    = 2'd1;
  localparam logic [1:0] ACT_CLEAR    = 2'd2;
  localparam logic [1:0] ACT_UNUSED   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SHORT = 2'd1;
  localparam logic [1:0] ST_MAGIC = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_JOINED  = 2'd1;
  localparam logic [1:0] EV_UPDATED = 2'd2;
  localparam logic [1:0] EV_LEFT    = 2'd3;

  localparam logic [1:0] CFG_SELF_MAC = 2'd0;
  localparam logic [1:0] CFG_TIMEOUT  = 2'd1;
  localparam logic [1:0] CFG_MAGIC    = 2'd2;

  typedef struct packed {
    logic [47:0] addr;
    logic [7:0]  role;
    logic [7:0]  links;
    logic [15:0] version;
    logic [15:0] state_bits;
    logic [31:0] seen_time;
    logic [31:0] beats;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_WRITE, S_SWEEP, S_LEFT, S_WAIT, S_EMIT
  } state_t;

endpackage

// ----- hw/rtl/peer_table_with_aging_core.sv -----
// Peer table with aging. Sixteen peer entries live in a synchronous memory with
// registered reads; valid and online marks are flip-flops, so reset and
// a clear item empty the table at once. An announce that passes the length,
// magic and own-address checks scans all slots, one memory read a cycle, to find
// a matching address, then writes the refreshed entry back, or a new entry in the
// lowest free slot, and then loads its result into the output register. A sweep
// first reads every slot and marks the stale entries offline, so that all of
// its results carry the final counts; it then reads each stale entry again and
// sends one "left" transfer for it, or a single result for a quiet sweep.
// While the output register holds a transfer that is not taken, the block waits
// before it can load the next result. The block works on one item at a time;
// in_tready is high only when it is idle, which is the cycle after the final
// result is loaded.
module peer_table_with_aging_core
  import pta_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // tdata from bit 0: now_time(32) packet_len(8) packet_magic(16) src_mac(48)
  // peer_role(8) peer_links(8) peer_fw(16) peer_flags(16)
  input  logic [151:0] in_tdata,
  // tuser: action(2)
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // tdata from bit 0: status(2) slot_index(4) device_mac(48) online_count(5)
  // total_count(5)
  output logic [63:0]  out_tdata,
  // tuser: event_kind(2)
  output logic [1:0]   out_tuser,
  output logic         out_tlast,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [47:0]  cfg_wdata
);

  logic [47:0] self_mac_r;
  logic [31:0] timeout_r;
  logic [15:0] magic_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      self_mac_r <= '0;
      timeout_r  <= 32'd30000;
      magic_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SELF_MAC: self_mac_r <= cfg_wdata;
        CFG_TIMEOUT:  timeout_r  <= cfg_wdata[31:0];
        CFG_MAGIC:    magic_r    <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Entry memory.
  entry_t mem [TableEntries];
  entry_t rd_ent_r;
  logic [SlotW-1:0] rd_addr;
  logic mem_we;
  logic [SlotW-1:0] wr_addr;
  entry_t wr_data;

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    rd_ent_r <= mem[rd_addr];
  end

  logic [TableEntries-1:0] valid_r, valid_nxt, online_r, online_nxt;
  logic [TableEntries-1:0] stale_r, stale_nxt;   // entries a sweep took offline
  state_t state_r, state_nxt;
  logic [151:0] item_r;
  logic [1:0] act_r;
  logic [SlotW:0] cnt_r, cnt_nxt;       // read issue counter
  logic rdv_r, rdv_nxt;                 // rd_ent_r holds slot rslot_r
  logic [SlotW-1:0] rslot_r, rslot_nxt;
  logic hit_r, hit_nxt;
  logic [SlotW-1:0] hslot_r, hslot_nxt;
  entry_t hent_r, hent_nxt;
  logic joined_r, joined_nxt;

  logic ovalid_r, ovalid_nxt, olast_r, olast_nxt;
  logic [1:0] ost_r, ost_nxt, oev_r, oev_nxt;
  logic [SlotW-1:0] oslot_r, oslot_nxt;
  logic [47:0] omac_r, omac_nxt;
  logic [CountW-1:0] oon_r, oon_nxt, otot_r, otot_nxt;

  logic [31:0] item_now;
  logic [7:0]  item_len;
  logic [15:0] item_magic;
  logic [47:0] item_src;
  assign item_now   = item_r[31:0];
  assign item_len   = item_r[39:32];
  assign item_magic = item_r[55:40];
  assign item_src   = item_r[103:56];

  logic [SlotW-1:0] free_slot;
  logic free_any;
  always_comb begin
    free_slot = '0;
    free_any  = 1'b0;
    for (int i = TableEntries - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_slot = SlotW'(i);
        free_any  = 1'b1;
      end
    end
  end

  // Lowest stale entry that still owes a "left" transfer.
  logic [SlotW-1:0] left_slot;
  always_comb begin
    left_slot = '0;
    for (int i = TableEntries - 1; i >= 0; i--) begin
      if (stale_r[i]) left_slot = SlotW'(i);
    end
  end

  logic [CountW-1:0] on_cnt, tot_cnt;
  always_comb begin
    on_cnt  = '0;
    tot_cnt = '0;
    for (int i = 0; i < TableEntries; i++) begin
      tot_cnt = tot_cnt + CountW'(valid_r[i]);
      on_cnt  = on_cnt + CountW'(valid_r[i] & online_r[i]);
    end
  end

  logic out_free;
  assign out_free = !ovalid_r || out_tready;
  logic [31:0] age;
  assign age = item_now - rd_ent_r.seen_time;

  always_comb begin
    state_nxt = state_r;
    valid_nxt = valid_r;
    online_nxt = online_r;
    stale_nxt = stale_r;
    cnt_nxt = cnt_r;
    rdv_nxt = 1'b0;
    rslot_nxt = rslot_r;
    hit_nxt = hit_r;
    hslot_nxt = hslot_r;
    hent_nxt = hent_r;
    joined_nxt = joined_r;
    ovalid_nxt = ovalid_r && !out_tready;
    olast_nxt = olast_r;
    ost_nxt = ost_r;
    oev_nxt = oev_r;
    oslot_nxt = oslot_r;
    omac_nxt = omac_r;
    oon_nxt = oon_r;
    otot_nxt = otot_r;
    rd_addr = cnt_r[SlotW-1:0];
    mem_we = 1'b0;
    wr_addr = hslot_r;
    wr_data = hent_r;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cnt_nxt = '0;
          hit_nxt = 1'b0;
          joined_nxt = 1'b0;
          stale_nxt = '0;
          case (in_tuser)
            ACT_ANNOUNCE: state_nxt = S_SCAN;
            ACT_SWEEP:    state_nxt = S_SWEEP;
            ACT_CLEAR: begin
              valid_nxt = '0;
              online_nxt = '0;
              state_nxt = S_EMIT;
            end
            default: state_nxt = S_EMIT;
          endcase
        end
      end
      S_SCAN: begin
        if (item_len < 8'(MinPacketLen) || item_magic != magic_r ||
            item_src == self_mac_r) begin
          state_nxt = S_EMIT;
        end else begin
          if (rdv_r && valid_r[rslot_r] && !hit_r && rd_ent_r.addr == item_src) begin
            hit_nxt = 1'b1;
            hslot_nxt = rslot_r;
            hent_nxt = rd_ent_r;
          end
          if (!cnt_r[SlotW]) begin
            rdv_nxt = 1'b1;
            rslot_nxt = cnt_r[SlotW-1:0];
            cnt_nxt = cnt_r + (SlotW+1)'(1);
          end else if (!rdv_r) begin
            state_nxt = S_WRITE;
          end
        end
      end
      S_WRITE: begin
        if (hit_r || free_any) begin
          mem_we = 1'b1;
          wr_addr = hit_r ? hslot_r : free_slot;
          wr_data.addr = item_src;
          wr_data.role = item_r[111:104];
          wr_data.links = item_r[119:112];
          wr_data.version = item_r[135:120];
          wr_data.state_bits = item_r[151:136];
          wr_data.seen_time = item_now;
          wr_data.beats = (hit_r ? hent_r.beats : 32'd0) + 32'd1;
          valid_nxt[wr_addr] = 1'b1;
          online_nxt[wr_addr] = 1'b1;
          hslot_nxt = wr_addr;
          // A new entry or one that had gone offline reports joined.
          joined_nxt = !hit_r || !online_r[hslot_r];
        end
        state_nxt = S_EMIT;
      end
      S_SWEEP: begin
        // First pass: take every stale entry offline and remember it.
        if (rdv_r && valid_r[rslot_r] && online_r[rslot_r] && age > timeout_r) begin
          online_nxt[rslot_r] = 1'b0;
          stale_nxt[rslot_r] = 1'b1;
        end
        if (!cnt_r[SlotW]) begin
          rdv_nxt = 1'b1;
          rslot_nxt = cnt_r[SlotW-1:0];
          cnt_nxt = cnt_r + (SlotW+1)'(1);
        end else if (!rdv_r) begin
          state_nxt = S_LEFT;
        end
      end
      S_LEFT: begin
        // Second pass: fetch the address of the next stale entry.
        rd_addr = left_slot;
        if (stale_r == '0) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        rd_addr = left_slot;
        if (out_free) begin
          stale_nxt[left_slot] = 1'b0;
          ovalid_nxt = 1'b1;
          olast_nxt = (stale_nxt == '0);
          ost_nxt = ST_OK;
          oev_nxt = EV_LEFT;
          oslot_nxt = left_slot;
          omac_nxt = rd_ent_r.addr;
          oon_nxt = on_cnt;
          otot_nxt = tot_cnt;
          state_nxt = (stale_nxt == '0) ? S_IDLE : S_LEFT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          olast_nxt = 1'b1;
          ost_nxt = ST_OK;
          oev_nxt = EV_NONE;
          oslot_nxt = '0;
          omac_nxt = '0;
          oon_nxt = on_cnt;
          otot_nxt = tot_cnt;
          if (act_r == ACT_ANNOUNCE) begin
            if (item_len < 8'(MinPacketLen)) ost_nxt = ST_SHORT;
            else if (item_magic != magic_r) ost_nxt = ST_MAGIC;
            else if (item_src == self_mac_r) ost_nxt = ST_OK;
            else if (!hit_r && !joined_r) ost_nxt = ST_FULL;
            else begin
              oev_nxt = joined_r ? EV_JOINED : EV_UPDATED;
              oslot_nxt = hslot_r;
              omac_nxt = item_src;
            end
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      online_r <= '0;
      stale_r <= '0;
      ovalid_r <= 1'b0;
      rdv_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      online_r <= online_nxt;
      stale_r <= stale_nxt;
      ovalid_r <= ovalid_nxt;
      rdv_r <= rdv_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= in_tdata;
      act_r <= in_tuser;
    end
    rslot_r <= rslot_nxt;
    hit_r <= hit_nxt;
    hslot_r <= hslot_nxt;
    hent_r <= hent_nxt;
    joined_r <= joined_nxt;
    olast_r <= olast_nxt;
    ost_r <= ost_nxt;
    oev_r <= oev_nxt;
    oslot_r <= oslot_nxt;
    omac_r <= omac_nxt;
    oon_r <= oon_nxt;
    otot_r <= otot_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tlast  = olast_r;
  assign out_tuser  = oev_r;
  assign out_tdata  = {otot_r, oon_r, omac_r, oslot_r, ost_r};

`ifndef SYNTH
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> state_r == S_IDLE) else $error("ready outside idle");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r && !out_tready |=> ovalid_r && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast)) else $error("result changed while stalled");
  a_online_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (online_r & ~valid_r) == '0) else $error("online without valid");
  a_counts: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r |-> (oon_r <= otot_r) && (otot_r <= CountW'(TableEntries)))
    else $error("count out of range");
`endif

endmodule

// ----- bench/tb.sv -----
module tb;
  import pta_pkg::*;

  // One expected result transfer, split into the fields the block reports.
  typedef struct {
    logic [1:0]  status;
    logic [1:0]  kind;
    logic [3:0]  slot;
    logic [47:0] mac;
    logic [4:0]  online;
    logic [4:0]  total;
    logic        last;
  } peer_event_t;

  // Scoreboard: holds its own copy of the peer table and the register values,
  // works out the events each accepted item causes, and checks result
  // transfers against them in order.
  class peer_table_sb;
    logic [47:0] own_addr;
    logic [31:0] timeout;
    logic [15:0] magic;
    bit          valid_q [TableEntries];
    bit          online_q [TableEntries];
    logic [47:0] addr_q [TableEntries];
    logic [31:0] seen_q [TableEntries];
    logic [31:0] beats_q [TableEntries];
    peer_event_t pending [$];
    int          mismatches;

    function void wipe();
      for (int i = 0; i < TableEntries; i++) begin
        valid_q[i] = 0;
        online_q[i] = 0;
        addr_q[i] = '0;
        seen_q[i] = '0;
        beats_q[i] = '0;
      end
    endfunction

    function void reset_state();
      own_addr = '0;
      timeout = 32'd30000;
      magic = '0;
      mismatches = 0;
      wipe();
    endfunction

    function void write_reg(logic [1:0] idx, logic [47:0] val);
      case (idx)
        CFG_SELF_MAC: own_addr = val;
        CFG_TIMEOUT:  timeout = val[31:0];
        CFG_MAGIC:    magic = val[15:0];
        default: ;
      endcase
    endfunction

    // Note an accepted input transfer and queue the events it should produce.
    function void note_item(logic [1:0] act, logic [151:0] d);
      logic [31:0] now;
      logic [7:0]  plen;
      logic [15:0] pmagic;
      logic [47:0] src;
      logic [31:0] age;
      peer_event_t step_q [$];
      peer_event_t ev;
      int slot, on, tot;
      bit fresh;
      now = d[31:0];
      plen = d[39:32];
      pmagic = d[55:40];
      src = d[103:56];
      ev = '{ST_OK, EV_NONE, 4'd0, 48'd0, 5'd0, 5'd0, 1'b0};
      if (act == ACT_ANNOUNCE) begin
        if (plen < MinPacketLen) begin
          ev.status = ST_SHORT;
          step_q.push_back(ev);
        end else if (pmagic != magic) begin
          ev.status = ST_MAGIC;
          step_q.push_back(ev);
        end else if (src == own_addr) begin
          step_q.push_back(ev);
        end else begin
          slot = -1;
          fresh = 0;
          for (int i = 0; i < TableEntries; i++)
            if (slot < 0 && valid_q[i] && addr_q[i] == src) slot = i;
          if (slot < 0) begin
            for (int i = 0; i < TableEntries; i++)
              if (slot < 0 && !valid_q[i]) slot = i;
            if (slot >= 0) begin
              fresh = 1;
              valid_q[slot] = 1;
              beats_q[slot] = '0;
              addr_q[slot] = src;
            end
          end
          if (slot < 0) begin
            ev.status = ST_FULL;
          end else begin
            // A returning device that had gone offline counts as joined again.
            ev.kind = (fresh || !online_q[slot]) ? EV_JOINED : EV_UPDATED;
            online_q[slot] = 1;
            seen_q[slot] = now;
            beats_q[slot] = beats_q[slot] + 1;
            ev.slot = slot[3:0];
            ev.mac = src;
          end
          step_q.push_back(ev);
        end
      end else if (act == ACT_SWEEP) begin
        for (int i = 0; i < TableEntries; i++) begin
          if (valid_q[i] && online_q[i] && step_q.size() < 16) begin
            age = now - seen_q[i];
            if (age > timeout) begin
              online_q[i] = 0;
              ev.kind = EV_LEFT;
              ev.slot = i[3:0];
              ev.mac = addr_q[i];
              step_q.push_back(ev);
            end
          end
        end
        if (step_q.size() == 0) step_q.push_back(ev);
      end else begin
        if (act == ACT_CLEAR) wipe();
        step_q.push_back(ev);
      end
      on = 0;
      tot = 0;
      for (int i = 0; i < TableEntries; i++) begin
        if (valid_q[i]) begin
          tot++;
          if (online_q[i]) on++;
        end
      end
      foreach (step_q[k]) begin
        step_q[k].online = on[4:0];
        step_q[k].total = tot[4:0];
        step_q[k].last = (k == step_q.size() - 1);
        pending.push_back(step_q[k]);
      end
    endfunction

    // Check one result transfer against the oldest expected event.
    function void check_result(logic [63:0] d, logic [1:0] kind, logic last);
      peer_event_t want;
      bit bad;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer: data %h", d);
        return;
      end
      want = pending.pop_front();
      bad = (d[1:0] !== want.status) || (d[5:2] !== want.slot) ||
            (d[53:6] !== want.mac) || (d[58:54] !== want.online) ||
            (d[63:59] !== want.total) || (kind !== want.kind) ||
            (last !== want.last);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $write("mismatch: exp st %0d ev %0d slot %0d mac %h on %0d tot %0d last %0d;",
                 want.status, want.kind, want.slot, want.mac, want.online,
                 want.total, want.last);
          $display(" got st %0d ev %0d slot %0d mac %h on %0d tot %0d last %0d",
                   d[1:0], kind, d[5:2], d[53:6], d[58:54], d[63:59], last);
        end
      end
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [151:0] in_tdata;
  logic [1:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [63:0]  out_tdata;
  logic [1:0]   out_tuser;
  logic         out_tlast;
  logic         cfg_we;
  logic [1:0]   cfg_index;
  logic [47:0]  cfg_wdata;

  peer_table_sb tracker;
  longint unsigned cycle_count;
  bit          rx_calm;
  logic [47:0] peer_pool [8];

  peer_table_with_aging_core i_dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Drive a single transfer on the input channel after a random gap (none when
  // no_gap is set), and hand it to the scoreboard at the edge that accepts it.
  // The block is busy in the cycle after it takes an item, so the task drops in_tvalid and lets the block start.
  task automatic send_item(logic [1:0] act, logic [151:0] d, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 14);
    repeat (gap) @(posedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= d;
    in_tuser <= act;
    do @(posedge clk); while (!in_tready);
    tracker.note_item(act, d);
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // Pack one announcement into the tdata layout.
  function automatic logic [151:0] pack_ann(logic [31:0] now, logic [7:0] plen,
      logic [15:0] pmagic, logic [47:0] src, logic [7:0] role, logic [7:0] links,
      logic [15:0] fw, logic [15:0] flags);
    return {flags, fw, links, role, src, pmagic, plen, now};
  endfunction

  // A sweep only looks at the time stamp.
  function automatic logic [151:0] sweep_data(logic [31:0] now);
    return {120'd0, now};
  endfunction

  function automatic logic [151:0] rand_fields();
    logic [159:0] r;
    r = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    return r[151:0];
  endfunction

  // Wait until every expected result transfer has arrived, then let the block
  // settle before registers are touched.
  task automatic drain();
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [47:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    tracker.write_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_ann(logic [31:0] now, logic [47:0] src);
    send_item(ACT_ANNOUNCE, pack_ann(now, 8'd32 + 8'($urandom_range(0, 223)),
              tracker.magic, src, 8'($urandom()), 8'($urandom()), 16'($urandom()),
              16'($urandom())));
  endtask

  // Result side: random stalls drawn per transfer, with calm stretches where
  // out_tready stays high throughout.
  initial begin
    int stall;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = rx_calm ? 0 : $urandom_range(0, 14);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      tracker.check_result(out_tdata, out_tuser, out_tlast);
    end
  end

  // Watchdog: the slowest legal run stays far below this bound.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 400000) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] t;
    logic [151:0] d;
    int pick;
    tracker = new();
    tracker.reset_state();
    rx_calm = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = ACT_ANNOUNCE;
    cfg_we = 1'b0;
    cfg_index = CFG_SELF_MAC;
    cfg_wdata = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part with reset register values: magic zero, own address zero.
    send_item(ACT_ANNOUNCE, pack_ann(32'd100, 8'd31, 16'd0, 48'h1, 8'd1, 8'd1,
              16'd1, 16'd1));                                  // too short
    send_item(ACT_ANNOUNCE, pack_ann(32'd100, 8'd32, 16'hFFFF, 48'h1, 8'd1, 8'd1,
              16'd1, 16'd1));                                  // bad magic
    send_item(ACT_ANNOUNCE, pack_ann(32'd100, 8'd255, 16'd0, 48'h0, 8'hFF, 8'hFF,
              16'hFFFF, 16'hFFFF));                            // own address
    send_item(ACT_SWEEP, sweep_data(32'd0));                    // quiet sweep
    send_item(ACT_UNUSED, rand_fields());                       // unused action
    drain();
    write_reg(CFG_SELF_MAC, 48'hFFFF_FFFF_FFFF);
    write_reg(CFG_MAGIC, 48'hA55A);
    write_reg(CFG_TIMEOUT, 48'd1000);
    // Fill the table completely, then overflow it.
    for (int i = 0; i < 17; i++)
      send_ann(32'hFFFF_FF00, (i == 0) ? 48'h0 : 48'h0000_1000 + 48'(i));
    // Same device again: updated. Own all-ones address: ignored.
    send_ann(32'hFFFF_FF10, 48'h0000_1001);
    send_ann(32'hFFFF_FF10, 48'hFFFF_FFFF_FFFF);
    // Sweep across the wrap: every entry is stale, sixteen left results.
    send_item(ACT_SWEEP, sweep_data(32'd2000));
    send_ann(32'd2100, 48'h0000_1001);                          // returning
    send_item(ACT_CLEAR, rand_fields());
    // Pause until the block has answered everything so far.
    drain();

    // Random part, in phases with different register settings.
    for (int phase = 0; phase < 4; phase++) begin
      write_reg(CFG_SELF_MAC, (phase == 3) ? 48'h0 : 48'({$urandom(), $urandom()}));
      write_reg(CFG_MAGIC, (phase == 2) ? 48'hFFFF : 48'(16'($urandom())));
      write_reg(CFG_TIMEOUT, (phase == 0) ? 48'd0 : (phase == 1) ? 48'hFFFF_FFFF :
                48'($urandom_range(50, 5000)));
      for (int k = 0; k < 8; k++) peer_pool[k] = 48'({$urandom(), $urandom()});
      peer_pool[0] = tracker.own_addr;
      t = $urandom();
      rx_calm = (phase == 1);
      for (int n = 0; n < 51; n++) begin
        t = t + $urandom_range(0, 3000);
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          send_ann(t, (pick < 50) ? peer_pool[$urandom_range(0, 7)] :
                   48'({$urandom(), $urandom()}));
        end else if (pick < 80) begin
          send_item(ACT_SWEEP, sweep_data(t) | (rand_fields() & ~152'hFFFF_FFFF),
                    n[0]);
        end else if (pick < 94) begin
          d = rand_fields();
          if ($urandom_range(0, 1)) d[55:40] = tracker.magic;
          send_item(ACT_ANNOUNCE, d);
        end else if (pick < 97) begin
          send_item(ACT_CLEAR, rand_fields());
        end else begin
          send_item(ACT_UNUSED, rand_fields());
        end
      end
      drain();
    end
    rx_calm = 1;
    repeat (50) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
